[sv/agas_pkg.sv]
// Shared types and constants of the affine-gap alignment cell sweep.
package agas_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OUT_SCORE_W = 32;
  localparam int unsigned OUT_MATCH_W = 16;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned PROD_W      = 26;
  localparam int unsigned COEF_W      = 8;
  localparam int unsigned FLOOR_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_BONUS      = 3'd0,
    CFG_MISMATCH_PENALTY = 3'd1,
    CFG_GAP_OPEN         = 3'd2,
    CFG_GAP_EXTEND       = 3'd3,
    CFG_SCORE_FLOOR      = 3'd4,
    CFG_ROW_LENGTH       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_first;
    logic [CHAR_W-1:0] char_second;
    logic              start_matrix;
  } cell_req_t;

  typedef struct packed {
    logic signed [OUT_SCORE_W-1:0] best_score;
    logic [OUT_MATCH_W-1:0]        best_matches;
    logic                          row_end;
  } cell_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

endpackage

[sv/agas_stream_if.sv]
// Valid/ready channel carrying one payload of a parameter type.
interface agas_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/affine_gap_alignment_cell_sweep_top.sv]
// Affine-gap alignment cell sweep: row store, lane update and output register.
//
// Cells of an alignment matrix arrive in row-major order, one request per cell, and the block
// returns one result per cell: the best of the substitution, vertical-gap and horizontal-gap
// lane scores, that lane's match count and a row-end flag. It sustains one cell per clock while
// results are accepted. The previous-row memory is read at the edge that takes the request; the
// lane update is then registered into the output stage, where the result becomes valid, and at
// the same edge into the left-neighbor register for the next cell. A result that waits at the
// output holds the lane stage and the
// request side. The previous row lives in a MAX_COLUMNS-entry memory read and written once per
// cell; with single-column rows the cell above is bypassed from the lane register. A request
// with start_matrix set begins a new matrix at its first cell. Registers may only be written
// while no request is in flight; writes to unknown indexes are ignored.
module affine_gap_alignment_cell_sweep_top #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned SCORE_BITS  = 32,
  parameter int unsigned MATCH_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  agas_stream_if.sink   in_i,
  agas_stream_if.source out_o,
  agas_stream_if.sink   cfg_i
);

  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned LW  = (CW + 1 > agas_pkg::LEN_W) ? CW + 1 : agas_pkg::LEN_W;
  localparam int unsigned AW  = (SCORE_BITS > 62) ? 66 :
                                ((SCORE_BITS + 2 > 34) ? SCORE_BITS + 2 : 34);
  localparam int unsigned LIM = (SCORE_BITS > 62) ? 64 : AW;
  localparam int unsigned MXW = MATCH_BITS + agas_pkg::OUT_MATCH_W;

  typedef logic signed [AW-1:0] wide_t;
  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [MATCH_BITS-1:0] match_t;

  typedef struct packed {
    logic [2:0][SCORE_BITS-1:0] sc;
    logic [2:0][MATCH_BITS-1:0] mt;
  } lanes_t;

  typedef enum logic [1:0] {
    LANE_S = 2'd0,
    LANE_D = 2'd1,
    LANE_I = 2'd2
  } lane_e;

  localparam wide_t  SAT_HI   = {{(AW-LIM+1){1'b0}}, {(LIM-1){1'b1}}};
  localparam wide_t  SAT_LO   = ~SAT_HI;
  localparam wide_t  TOP      = {{(AW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
  localparam wide_t  BOTTOM   = ~TOP;
  localparam match_t MATCH_MAX = {MATCH_BITS{1'b1}};
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_COLUMNS);

  // The int64 saturation of the scoring arithmetic only bites at 64-bit scores.
  function automatic wide_t sat(input wide_t x);
    wide_t r;
    r = x;
    if (x > SAT_HI) r = SAT_HI;
    if (x < SAT_LO) r = SAT_LO;
    return r;
  endfunction

  function automatic wide_t widen(input score_t x);
    return {{(AW-SCORE_BITS){x[SCORE_BITS-1]}}, x};
  endfunction

  function automatic score_t clamp(input wide_t x, input wide_t lo);
    wide_t r;
    r = x;
    if (x < lo) r = lo;
    else if (x > TOP) r = TOP;
    return r[SCORE_BITS-1:0];
  endfunction

  function automatic lane_e pick3(input wide_t a, input wide_t b, input wide_t c);
    lane_e r;
    if (a >= b && a >= c) r = LANE_S;
    else if (b >= c) r = LANE_D;
    else r = LANE_I;
    return r;
  endfunction

  // Configuration registers.
  logic signed [agas_pkg::COEF_W-1:0]  bonus_q, penalty_q, open_q, ext_q;
  logic signed [agas_pkg::FLOOR_W-1:0] floor_q;
  logic [agas_pkg::LEN_W-1:0]          row_length_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bonus_q      <= 8'sd1;
      penalty_q    <= -8'sd1;
      open_q       <= -8'sd2;
      ext_q        <= -8'sd1;
      floor_q      <= -32'sd1073741824;
      row_length_q <= 11'd1024;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        agas_pkg::CFG_MATCH_BONUS:      bonus_q <= cfg_i.payload.data[7:0];
        agas_pkg::CFG_MISMATCH_PENALTY: penalty_q <= cfg_i.payload.data[7:0];
        agas_pkg::CFG_GAP_OPEN:         open_q <= cfg_i.payload.data[7:0];
        agas_pkg::CFG_GAP_EXTEND:       ext_q <= cfg_i.payload.data[7:0];
        agas_pkg::CFG_SCORE_FLOOR:      floor_q <= cfg_i.payload.data;
        agas_pkg::CFG_ROW_LENGTH:
          row_length_q <= cfg_i.payload.data[agas_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lowest lane score: the floor register brought into the score range.
  wide_t lo;
  always_comb begin
    lo = AW'(floor_q);
    if (lo < BOTTOM) lo = BOTTOM;
    if (lo > TOP) lo = TOP;
  end

  // Pipeline control.
  logic s1_valid_q, s2_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv      = !s2_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = s2_valid_q;

  // Request stage: position, row end and boundary lanes.
  logic [CW-1:0]             col_q, cur_col;
  logic [agas_pkg::ROW_W-1:0] row_q, cur_row;
  logic [LW-1:0]             len_eff, col_next;
  logic                      row_end;
  logic [agas_pkg::POS_W-1:0] col_pos, row_pos;
  logic signed [agas_pkg::PROD_W-1:0] top_prod, left_prod;
  wide_t                     top_raw, left_raw, diag_raw;

  always_comb begin
    cur_col = in_i.payload.start_matrix ? '0 : col_q;
    cur_row = in_i.payload.start_matrix ? '0 : row_q;
    len_eff = LW'(row_length_q);
    if (len_eff == '0) len_eff = LW'(1);
    if (len_eff > LEN_MAX) len_eff = LEN_MAX;
    col_next = LW'(cur_col) + LW'(1);
    row_end  = col_next >= len_eff;
    col_pos  = agas_pkg::POS_W'(cur_col) + agas_pkg::POS_W'(1);
    row_pos  = agas_pkg::POS_W'(cur_row) + agas_pkg::POS_W'(1);
    top_prod  = agas_pkg::PROD_W'(signed'({1'b0, col_pos})) * agas_pkg::PROD_W'(ext_q);
    left_prod = agas_pkg::PROD_W'(signed'({1'b0, row_pos})) * agas_pkg::PROD_W'(ext_q);
    top_raw  = AW'(open_q) + AW'(top_prod);
    left_raw = AW'(open_q) + AW'(left_prod);
    diag_raw = left_raw - AW'(ext_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        if (cur_row != '1) row_q <= cur_row + agas_pkg::ROW_W'(1);
        else row_q <= cur_row;
      end else begin
        col_q <= col_next[CW-1:0];
        row_q <= cur_row;
      end
    end
  end

  // Lane stage registers.
  logic [CW-1:0] s1_col_q;
  logic          s1_row0_q, s1_col0_q, s1_equal_q, s1_hit_q, s1_end_q;
  score_t        s1_top_q, s1_left_q, s1_diag_q;
  lanes_t        rd_q, left_q, diag_q, nw;

  lanes_t row_mem [MAX_COLUMNS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      row_mem[s1_col_q] <= nw;
    end
    if (in_acc) begin
      rd_q <= row_mem[cur_col];
    end
  end

  lanes_t up, lf, dg;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= cur_col;
      s1_row0_q  <= cur_row == '0;
      s1_col0_q  <= cur_col == '0;
      s1_equal_q <= in_i.payload.char_first == in_i.payload.char_second;
      // The cell being finished this cycle writes the entry this request reads.
      s1_hit_q   <= s1_valid_q && (s1_col_q == cur_col);
      s1_end_q   <= row_end;
      s1_top_q   <= clamp(top_raw, lo);
      s1_left_q  <= clamp(left_raw, lo);
      s1_diag_q  <= clamp(diag_raw, lo);
    end
    if (s1_valid_q && s1_adv) begin
      left_q <= nw;
      diag_q <= up;
    end
  end

  // Lane update.
  lane_e ws, wd, wi;
  wide_t add, da, db, dc, ia, ib, ic, sv;
  score_t lo_s;

  always_comb begin
    lo_s = lo[SCORE_BITS-1:0];

    if (s1_row0_q) begin
      up.sc = {s1_top_q, lo_s, lo_s};
      up.mt = '0;
    end else if (s1_hit_q) begin
      up = left_q;
    end else begin
      up = rd_q;
    end

    if (s1_col0_q) begin
      lf.sc = {lo_s, s1_left_q, lo_s};
      lf.mt = '0;
      if (s1_row0_q) begin
        dg = '0;
      end else begin
        dg.sc = {lo_s, s1_diag_q, lo_s};
        dg.mt = '0;
      end
    end else begin
      lf = left_q;
      dg = diag_q;
    end

    add = s1_equal_q ? AW'(bonus_q) : AW'(penalty_q);
    ws  = pick3(widen(dg.sc[LANE_S]), widen(dg.sc[LANE_D]), widen(dg.sc[LANE_I]));
    sv  = sat(widen(dg.sc[ws]) + add);
    nw.sc[LANE_S] = clamp(sv, lo);
    nw.mt[LANE_S] = dg.mt[ws];
    if (s1_equal_q && dg.mt[ws] != MATCH_MAX) nw.mt[LANE_S] = dg.mt[ws] + match_t'(1);

    da = sat(sat(widen(up.sc[LANE_S]) + AW'(open_q)) + AW'(ext_q));
    db = sat(widen(up.sc[LANE_D]) + AW'(ext_q));
    dc = sat(sat(widen(up.sc[LANE_I]) + AW'(open_q)) + AW'(ext_q));
    wd = pick3(da, db, dc);
    case (wd)
      LANE_S:  nw.sc[LANE_D] = clamp(da, lo);
      LANE_D:  nw.sc[LANE_D] = clamp(db, lo);
      default: nw.sc[LANE_D] = clamp(dc, lo);
    endcase
    nw.mt[LANE_D] = up.mt[wd];

    ia = sat(sat(widen(lf.sc[LANE_S]) + AW'(open_q)) + AW'(ext_q));
    ib = sat(sat(widen(lf.sc[LANE_D]) + AW'(open_q)) + AW'(ext_q));
    ic = sat(widen(lf.sc[LANE_I]) + AW'(ext_q));
    wi = pick3(ia, ib, ic);
    case (wi)
      LANE_S:  nw.sc[LANE_I] = clamp(ia, lo);
      LANE_D:  nw.sc[LANE_I] = clamp(ib, lo);
      default: nw.sc[LANE_I] = clamp(ic, lo);
    endcase
    nw.mt[LANE_I] = lf.mt[wi];
  end

  // Output register and best-lane select.
  lanes_t s2_lanes_q;
  logic   s2_end_q;
  lane_e  wb;
  wide_t  best_wide;
  logic [MXW-1:0] best_mt;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      s2_lanes_q <= nw;
      s2_end_q   <= s1_end_q;
    end
  end

  always_comb begin
    wb = pick3(widen(s2_lanes_q.sc[LANE_S]), widen(s2_lanes_q.sc[LANE_D]),
               widen(s2_lanes_q.sc[LANE_I]));
    best_wide = widen(s2_lanes_q.sc[wb]);
    best_mt   = MXW'(s2_lanes_q.mt[wb]);
    out_o.payload.best_score   = best_wide[agas_pkg::OUT_SCORE_W-1:0];
    out_o.payload.best_matches = best_mt[agas_pkg::OUT_MATCH_W-1:0];
    out_o.payload.row_end      = s2_end_q;
  end

endmodule
